### rtl/vta_pkg.sv
package vta_pkg;

	// register indexes on the write port
	localparam logic [2:0] REG_COL_X  = 3'd0;
	localparam logic [2:0] REG_COL_Y  = 3'd1;
	localparam logic [2:0] REG_COL_Z  = 3'd2;
	localparam logic [2:0] REG_COL_W  = 3'd3;
	localparam logic [2:0] REG_SCALE  = 3'd4;
	localparam logic [2:0] REG_ORG_X  = 3'd5;
	localparam logic [2:0] REG_ORG_Y  = 3'd6;

	// reset values: identity matrix, unit scale, origin at (320,240)
	localparam logic [63:0] RST_COL_X = 64'd256;
	localparam logic [63:0] RST_COL_Y = 64'd16777216;
	localparam logic [63:0] RST_COL_Z = 64'd1099511627776;
	localparam logic [63:0] RST_COL_W = 64'd72057594037927936;
	localparam logic [15:0] RST_SCALE = 16'd256;
	localparam logic [11:0] RST_ORG_X = 12'd320;
	localparam logic [11:0] RST_ORG_Y = 12'd240;

	// projection cosines in Q0.16
	localparam logic [15:0] COS_B_Q16 = 16'd46341;
	localparam logic [15:0] COS_A_Q16 = 16'd53508;

	// datapath widths
	localparam int ACC_W  = 34;
	localparam int Q_W    = 51;
	localparam int QMAG_W = 49;
	localparam int HMAG_W = 33;
	localparam int PMAG_W = 41;
	localparam int OFF_W  = 57;
	localparam int S_W    = 59;

	localparam logic [PMAG_W-1:0] P_LIMIT = {1'b1, {(PMAG_W-1){1'b0}}};

	// tag carried with each vertex through the divider
	typedef struct packed {
		logic pen_up;
		logic dashed;
		logic last;
		logic zero_w;
		logic neg;
	} vtx_tag_t;

	function automatic logic signed [15:0] coef(input logic [63:0] col, input int unsigned row);
		coef = col[16*row +: 16];
	endfunction

endpackage

### rtl/vertex_transform_axonometric_unit.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-----------------------------------------
// vertex    | in        | start & !busy         | x_in y_in z_in pen_up dashed_line last_vertex
// result    | out       | done, one cycle       | screen_x screen_y pen_up_out dashed_out
//           |           |                       | last_out zero_w_flag
// config    | in        | wr_en                 | wr_index wr_data
//
// one vertex is taken every cycle; busy is never raised
// the pipeline has 5 transform stages, 49 divider stages (one quotient bit
// each), 4 projection and output stages
// the receiver cannot stall, so the pipeline never holds; valid bits ride with the data
// reset clears the valid bits and loads the identity matrix, unit scale and origin
module vertex_transform_axonometric_unit import vta_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	input  logic signed [15:0] z_in,
	input  logic               pen_up,
	input  logic               dashed_line,
	input  logic               last_vertex,
	output logic               done,
	output logic signed [15:0] screen_x,
	output logic signed [15:0] screen_y,
	output logic               pen_up_out,
	output logic               dashed_out,
	output logic               last_out,
	output logic               zero_w_flag,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [63:0]        wr_data
);

	logic [63:0] col_q [4];
	logic [15:0] scale_q;
	logic [11:0] org_x_q;
	logic [11:0] org_y_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0] <= RST_COL_X;
			col_q[1] <= RST_COL_Y;
			col_q[2] <= RST_COL_Z;
			col_q[3] <= RST_COL_W;
			scale_q  <= RST_SCALE;
			org_x_q  <= RST_ORG_X;
			org_y_q  <= RST_ORG_Y;
		end else if (wr_en) begin
			case (wr_index)
				REG_COL_X: col_q[0] <= wr_data;
				REG_COL_Y: col_q[1] <= wr_data;
				REG_COL_Z: col_q[2] <= wr_data;
				REG_COL_W: col_q[3] <= wr_data;
				REG_SCALE: scale_q  <= wr_data[15:0];
				REG_ORG_X: org_x_q  <= wr_data[11:0];
				REG_ORG_Y: org_y_q  <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	logic signed [15:0] vin [3];
	assign vin[0] = x_in;
	assign vin[1] = y_in;
	assign vin[2] = z_in;

	// valid and marks for the transform stages
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2:0] mark_s1, mark_s2, mark_s3, mark_s4, mark_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		mark_s1 <= {pen_up, dashed_line, last_vertex};
		mark_s2 <= mark_s1;
		mark_s3 <= mark_s2;
		mark_s4 <= mark_s3;
		mark_s5 <= mark_s4;
	end

	// stage 1: coefficient products
	logic signed [31:0] prod_s1 [4][3];

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[c][r] <= coef(col_q[c], r) * vin[r];
			end
		end
	end

	// stage 2: row sums plus translation
	logic signed [ACC_W-1:0] acc_s2 [4];

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			acc_s2[c] <= ACC_W'(prod_s1[c][0]) + ACC_W'(prod_s1[c][1])
				+ ACC_W'(prod_s1[c][2]) + ACC_W'(coef(col_q[c], 3));
		end
	end

	// stage 3: z' times the projection cosines
	logic signed [ACC_W-1:0] ax_s3, ay_s3, h_s3;
	logic signed [Q_W-1:0]   bz_s3, az_s3;

	always_ff @(posedge clk) begin
		ax_s3 <= acc_s2[0];
		ay_s3 <= acc_s2[1];
		h_s3  <= acc_s2[3];
		bz_s3 <= acc_s2[2] * $signed({1'b0, COS_B_Q16});
		az_s3 <= acc_s2[2] * $signed({1'b0, COS_A_Q16});
	end

	// stage 4: numerators
	logic signed [Q_W-1:0]   qx_s4, qy_s4;
	logic signed [ACC_W-1:0] h_s4;

	always_ff @(posedge clk) begin
		qx_s4 <= $signed({ax_s3[ACC_W-1], ax_s3, 16'h0000}) - bz_s3;
		qy_s4 <= $signed({ay_s3[ACC_W-1], ay_s3, 16'h0000}) - az_s3;
		h_s4  <= h_s3;
	end

	// stage 5: magnitudes and quotient signs
	logic [Q_W-1:0]    qx_abs, qy_abs;
	logic [ACC_W-1:0]  h_abs;
	logic [QMAG_W-1:0] qxmag_s5, qymag_s5;
	logic [HMAG_W-1:0] hmag_s5;
	logic              negx_s5, negy_s5, zero_s5;

	assign qx_abs = qx_s4[Q_W-1] ? Q_W'(-qx_s4) : Q_W'(qx_s4);
	assign qy_abs = qy_s4[Q_W-1] ? Q_W'(-qy_s4) : Q_W'(qy_s4);
	assign h_abs  = h_s4[ACC_W-1] ? ACC_W'(-h_s4) : ACC_W'(h_s4);

	always_ff @(posedge clk) begin
		qxmag_s5 <= qx_abs[QMAG_W-1:0];
		qymag_s5 <= qy_abs[QMAG_W-1:0];
		hmag_s5  <= h_abs[HMAG_W-1:0];
		negx_s5  <= qx_s4[Q_W-1] ^ h_s4[ACC_W-1];
		negy_s5  <= qy_s4[Q_W-1] ^ h_s4[ACC_W-1];
		zero_s5  <= (h_s4 == '0);
	end

	// dividers for both axes
	vtx_tag_t          tagx_in, tagx_out;
	logic              dvld;
	logic [QMAG_W-1:0] quot_x, quot_y;
	logic              negy_d;

	assign tagx_in = '{pen_up: mark_s5[2], dashed: mark_s5[1], last: mark_s5[0],
		zero_w: zero_s5, neg: negx_s5};

	vta_div #(
		.NUM_W(QMAG_W),
		.DEN_W(HMAG_W),
		.TAG_W($bits(vtx_tag_t))
	) u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s5),
		.num(qxmag_s5),
		.den(hmag_s5),
		.tag_in(tagx_in),
		.out_valid(dvld),
		.quot(quot_x),
		.tag_out(tagx_out)
	);

	vta_div #(
		.NUM_W(QMAG_W),
		.DEN_W(HMAG_W),
		.TAG_W(1)
	) u_div_y (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s5),
		.num(qymag_s5),
		.den(hmag_s5),
		.tag_in(negy_s5),
		.out_valid(),
		.quot(quot_y),
		.tag_out(negy_d)
	);

	// stage 6: clamp the projected offsets
	logic              vld_s6, vld_s7, vld_s8;
	vtx_tag_t          tag_s6, tag_s7, tag_s8;
	logic              negy_s6, negy_s7, negy_s8;
	logic [PMAG_W-1:0] magx_s6, magy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s6 <= dvld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			done   <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		tag_s6  <= tagx_out;
		tag_s7  <= tag_s6;
		tag_s8  <= tag_s7;
		negy_s6 <= negy_d;
		negy_s7 <= negy_s6;
		negy_s8 <= negy_s7;
		magx_s6 <= (quot_x > QMAG_W'(P_LIMIT)) ? P_LIMIT : quot_x[PMAG_W-1:0];
		magy_s6 <= (quot_y > QMAG_W'(P_LIMIT)) ? P_LIMIT : quot_y[PMAG_W-1:0];
	end

	// stage 7: apply the screen scale
	logic [OFF_W-1:0] offx_s7, offy_s7;

	always_ff @(posedge clk) begin
		offx_s7 <= magx_s6 * scale_q;
		offy_s7 <= magy_s6 * scale_q;
	end

	// stage 8: add to the origin, y axis points down
	logic signed [S_W-1:0] sx_s8, sy_s8;
	logic signed [S_W-1:0] orgx_ext, orgy_ext, offx_ext, offy_ext;

	assign orgx_ext = $signed({(S_W-36)'(0), org_x_q, 24'h000000});
	assign orgy_ext = $signed({(S_W-36)'(0), org_y_q, 24'h000000});
	assign offx_ext = $signed({(S_W-OFF_W)'(0), offx_s7});
	assign offy_ext = $signed({(S_W-OFF_W)'(0), offy_s7});

	always_ff @(posedge clk) begin
		sx_s8 <= tag_s7.neg ? orgx_ext - offx_ext : orgx_ext + offx_ext;
		sy_s8 <= negy_s7 ? orgy_ext + offy_ext : orgy_ext - offy_ext;
	end

	// output: truncate toward zero, saturate, zero-h override
	logic signed [S_W-25:0] rx, ry;

	assign rx = $signed(sx_s8[S_W-1:24])
		+ $signed({(S_W-25)'(0), sx_s8[S_W-1] & (|sx_s8[23:0])});
	assign ry = $signed(sy_s8[S_W-1:24])
		+ $signed({(S_W-25)'(0), sy_s8[S_W-1] & (|sy_s8[23:0])});

	function automatic logic signed [15:0] sat16(input logic signed [S_W-25:0] v);
		if (v > (S_W-24)'(32767)) begin
			sat16 = 16'sh7FFF;
		end else if (v < -(S_W-24)'(32768)) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		screen_x    <= tag_s8.zero_w ? 16'sh7FFF : sat16(rx);
		screen_y    <= tag_s8.zero_w ? 16'sh7FFF : sat16(ry);
		pen_up_out  <= tag_s8.pen_up;
		dashed_out  <= tag_s8.dashed;
		last_out    <= tag_s8.last;
		zero_w_flag <= tag_s8.zero_w;
	end

endmodule

### rtl/vta_div.sv
module vta_div import vta_pkg::*; #(
	parameter int NUM_W = QMAG_W,
	parameter int DEN_W = HMAG_W,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [NUM_W-1:0] quot,
	output logic [TAG_W-1:0] tag_out
);

	logic             vld_s [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [TAG_W-1:0] tag_s [NUM_W];

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic             vld_i;
		logic [DEN_W-1:0] rem_i;
		logic [NUM_W-1:0] num_i;
		logic [DEN_W-1:0] den_i;
		logic [TAG_W-1:0] tag_i;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;

		if (k == 0) begin : g_first
			assign vld_i = in_valid;
			assign rem_i = '0;
			assign num_i = num;
			assign den_i = den;
			assign tag_i = tag_in;
		end else begin : g_next
			assign vld_i = vld_s[k-1];
			assign rem_i = rem_s[k-1];
			assign num_i = num_s[k-1];
			assign den_i = den_s[k-1];
			assign tag_i = tag_s[k-1];
		end

		assign trial = {rem_i, num_i[NUM_W-1]};
		assign diff  = trial - {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
			num_s[k] <= {num_i[NUM_W-2:0], ~diff[DEN_W]};
			den_s[k] <= den_i;
			tag_s[k] <= tag_i;
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign quot      = num_s[NUM_W-1];
	assign tag_out   = tag_s[NUM_W-1];

endmodule
